/* design/plist_pkg.sv */
// Shared definitions for the positional list: field widths, operation and
// status codes, and the control word broadcast to the row of list cells.
// No dependencies.
package plist_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 8;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 7;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Operation seen by every cell in the cycle of a transfer.
    typedef struct packed {
        logic             do_insert;
        logic             do_delete;
        logic [POS_W-1:0] index;     // zero-based target slot
    } cell_op_t;

endpackage

/* design/plist_cell.sv */
// One slot of the positional list. On an insert it loads the new value or
// takes its left neighbor's entry; on a delete it takes its right neighbor's.
// Depends on plist_pkg.
module plist_cell #(
    parameter int IDX = 0
) (
    input  logic                           clk,
    input  plist_pkg::cell_op_t            op,
    input  logic [plist_pkg::DATA_W-1:0]   new_value,
    input  logic [plist_pkg::DATA_W-1:0]   left_value,
    input  logic [plist_pkg::DATA_W-1:0]   right_value,
    output logic [plist_pkg::DATA_W-1:0]   value
);
    import plist_pkg::*;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              at_target;
    logic              past_target;

    assign at_target   = (op.index == POS_W'(IDX));
    assign past_target = (op.index <  POS_W'(IDX));

    always_comb
    begin
        value_next = value_reg;
        priority if (op.do_insert && at_target)
        begin
            value_next = new_value;
        end
        else if (op.do_insert && past_target)
        begin
            value_next = left_value;
        end
        else if (op.do_delete && (at_target || past_target))
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* design/plist_ctrl.sv */
// Operation decoder and result register for the positional list: checks the
// position against the entry count, keeps the count and drives the output.
// Depends on plist_pkg.
module plist_ctrl #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  logic                               kind,
    input  logic [plist_pkg::POS_W-1:0]        position,
    input  logic [CAPACITY*plist_pkg::DATA_W-1:0] cells_flat,
    input  logic                               out_free,
    output plist_pkg::cell_op_t                op,
    output logic                               out_valid,
    output logic [plist_pkg::STATUS_W-1:0]     status,
    output logic [plist_pkg::DATA_W-1:0]       removed_value,
    output logic [plist_pkg::COUNT_OUT_W-1:0]  entry_count
);
    import plist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = POS_W + 1;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   valid_reg, valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [DATA_W-1:0]      removed_reg, removed_next;
    logic [CMP_W-1:0]       pos_w, count_w;
    logic [POS_W-1:0]       index;
    logic [DATA_W-1:0]      picked;
    logic                   is_empty, is_full;

    assign pos_w    = CMP_W'(position);
    assign count_w  = CMP_W'(count_reg);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign index    = position - POS_W'(1);
    assign picked   = cells_flat[index[IDX_W-1:0]*DATA_W +: DATA_W];

    always_comb
    begin
        op           = '0;
        count_next   = count_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        valid_next   = valid_reg;
        if (out_free)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next   = 1'b1;
            removed_next = '0;
            status_next  = ST_OK;
            if (kind == KIND_INSERT)
            begin
                // An empty list takes the value whatever the position.
                priority if (is_empty)
                begin
                    op.do_insert = 1'b1;
                    op.index     = '0;
                    count_next   = CNT_W'(1);
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else if (pos_w == '0 || pos_w > count_w + CMP_W'(1))
                begin
                    status_next = ST_BAD_POS;
                end
                else
                begin
                    op.do_insert = 1'b1;
                    op.index     = index;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                priority if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pos_w == '0 || pos_w > count_w)
                begin
                    status_next = ST_BAD_POS;
                end
                else
                begin
                    op.do_delete = 1'b1;
                    op.index     = index;
                    removed_next = picked;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    assign out_valid     = valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = COUNT_OUT_W'(count_reg);

endmodule

/* design/positional_list_insert_delete.sv */
// Positional list of up to CAPACITY signed 32-bit values with insert and
// delete at a one-based position. Depends on plist_pkg, plist_ctrl, plist_cell.
// Usage:
//   Input channel s_*: one transfer is one operation. s_tuser holds the kind
//   (insert or delete); s_tdata holds the position and the value to insert.
//   Output channel m_*: exactly one result transfer per operation, in order.
//   m_tuser holds the status; m_tdata the removed value and the entry count.
// Timing:
//   The list lives in a row of cells. On an insert every cell at or behind
//   the target slot shifts back by one in the same clock; on a delete they
//   shift forward. An operation therefore completes in the cycle it is
//   transferred, and its result appears on m_* in the next cycle.
//   Throughput is one operation per cycle while m_tready stays high.
// Reset:
//   rst_n clears the entry count and the output valid; cell contents are
//   left as they are and are only read below the count.
// Stall:
//   The result waits in the output register while m_tready is low, and
//   s_tready drops until it has been taken; a new operation is accepted in
//   the same cycle that the waiting result is transferred.
module positional_list_insert_delete #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [plist_pkg::S_TDATA_W-1:0]   s_tdata,   // position[7:0], value[39:8]
    input  logic                              s_tuser,   // kind[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [plist_pkg::M_TDATA_W-1:0]   m_tdata,   // removed_value[31:0],
                                                         // entry_count[38:32], zero[39]
    output logic [plist_pkg::STATUS_W-1:0]    m_tuser    // status[1:0]
);
    import plist_pkg::*;

    cell_op_t                    op;
    logic [CAPACITY*DATA_W-1:0]  cells_flat;
    logic [DATA_W-1:0]           new_value;
    logic [DATA_W-1:0]           removed_value;
    logic [COUNT_OUT_W-1:0]      entry_count;
    logic                        out_free;
    logic                        take;

    assign out_free  = !m_tvalid || m_tready;
    assign s_tready  = out_free;
    assign take      = s_tvalid && out_free;
    assign new_value = s_tdata[POS_W +: DATA_W];

    plist_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .kind          (s_tuser),
        .position      (s_tdata[POS_W-1:0]),
        .cells_flat    (cells_flat),
        .out_free      (out_free),
        .op            (op),
        .out_valid     (m_tvalid),
        .status        (m_tuser),
        .removed_value (removed_value),
        .entry_count   (entry_count)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = new_value;
        end
        else
        begin : g_mid
            assign left_value = cells_flat[(i-1)*DATA_W +: DATA_W];
        end

        // The last slot has no right neighbor; what it takes is past the count.
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner
            assign right_value = cells_flat[(i+1)*DATA_W +: DATA_W];
        end

        plist_cell #(
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .op          (op),
            .new_value   (new_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cells_flat[i*DATA_W +: DATA_W])
        );
    end

    assign m_tdata = {{(M_TDATA_W - DATA_W - COUNT_OUT_W){1'b0}}, entry_count, removed_value};

endmodule

/* design/plist_chk.sv */
// Port-level checker for the positional list, bound to the top level.
// Depends on plist_pkg and positional_list_insert_delete.
module plist_chk #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [plist_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [plist_pkg::STATUS_W-1:0]   m_tuser
);
    import plist_pkg::*;

    logic [COUNT_OUT_W-1:0] count_field;
    logic [DATA_W-1:0]      removed_field;

    assign count_field   = m_tdata[DATA_W +: COUNT_OUT_W];
    assign removed_field = m_tdata[DATA_W-1:0];

    // A result waiting for the receiver keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only a successful operation may return a nonzero removed value.
    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> removed_field == '0)
        else $error("removed value set on a failed operation");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_EMPTY |-> count_field == '0)
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_FULL |-> count_field == COUNT_OUT_W'(CAPACITY))
        else $error("full status with count below capacity");

endmodule

bind positional_list_insert_delete plist_chk #(
    .CAPACITY (CAPACITY)
) u_plist_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* dv/tb_top.sv */
// Self-checking testbench for positional_list_insert_delete: random and directed
// insert/delete transfers are checked against a shadow list kept in a scoreboard.
// Depends on plist_pkg and the positional_list_insert_delete RTL.
`timescale 1ns / 1ps

module tb_top;
    import plist_pkg::*;

    localparam int RANDOM_OPS   = 1750;
    localparam int PHASE_OPS    = 250;
    localparam int SEGMENT_OPS  = 100;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        logic                     kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } list_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] removed_value;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } list_result_t;

    // Shadow copy of the list; each accepted operation is applied here and its
    // expected result is queued for the output monitor.
    class list_scoreboard;
        logic [DATA_W-1:0] entries [CAPACITY_DEF];
        int unsigned       length;
        list_result_t      pending_results [$];
        int                errors;

        function new();
            length = 0;
            errors = 0;
        endfunction

        function void apply_op(list_op_t op);
            list_result_t res;
            int unsigned  pos;
            res.status        = ST_OK;
            res.removed_value = '0;
            pos               = op.position;
            if (op.kind == KIND_INSERT)
            begin
                if (length == 0)
                begin
                    // An empty list takes the value whatever the position.
                    entries[0] = op.value;
                    length     = 1;
                end
                else if (length >= CAPACITY_DEF)
                    res.status = ST_FULL;
                else if (pos < 1 || pos > length + 1)
                    res.status = ST_BAD_POS;
                else
                begin
                    for (int unsigned i = length; i > pos - 1; i--)
                        entries[i] = entries[i - 1];
                    entries[pos - 1] = op.value;
                    length++;
                end
            end
            else
            begin
                if (length == 0)
                    res.status = ST_EMPTY;
                else if (pos < 1 || pos > length)
                    res.status = ST_BAD_POS;
                else
                begin
                    res.removed_value = entries[pos - 1];
                    for (int unsigned i = pos - 1; i + 1 < length; i++)
                        entries[i] = entries[i + 1];
                    length--;
                end
            end
            res.entry_count = length[COUNT_OUT_W-1:0];
            pending_results.push_back(res);
        endfunction

        task report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, field, got, want);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [M_TDATA_W-1:0] tdata);
            list_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", tdata[DATA_W-1:0], '0);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status)
                report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
            if (tdata[31:0] !== want.removed_value)
                report_mismatch("removed_value", tdata[31:0], want.removed_value);
            if (tdata[38:32] !== want.entry_count)
                report_mismatch("entry_count", DATA_W'(tdata[38:32]),
                                DATA_W'(want.entry_count));
            if (tdata[39] !== 1'b0)
                report_mismatch("tdata pad bit", DATA_W'(tdata[39]), '0);
        endtask
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    list_scoreboard sb = new();
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             hold_left     = 0;
    int             cycle_count   = 0;

    positional_list_insert_delete dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one operation and hold it until the transfer happens.
    task automatic send_op(logic kind, logic [POS_W-1:0] position, logic [DATA_W-1:0] value);
        list_op_t op;
        op.kind     = kind;
        op.position = position;
        op.value    = value;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {value, position};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.apply_op(op);
    endtask

    task automatic idle_gap();
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_op(KIND_INSERT, 8'd0,   32'h7fff_ffff);  // empty list, position zero
        send_op(KIND_DELETE, 8'd0,   32'h0);
        send_op(KIND_DELETE, 8'd2,   32'h0);
        send_op(KIND_DELETE, 8'd1,   32'hffff_ffff);
        send_op(KIND_DELETE, 8'd1,   32'h0);           // empty list
        send_op(KIND_INSERT, 8'd255, 32'h8000_0000);  // empty list, far position
        send_op(KIND_INSERT, 8'd1,   32'hffff_ffff);
        send_op(KIND_INSERT, 8'd3,   32'h0);           // append at count+1
        send_op(KIND_INSERT, 8'd5,   32'h1);
        send_op(KIND_INSERT, 8'd0,   32'h2);
        send_op(KIND_INSERT, 8'd2,   32'h1234_5678);
        send_op(KIND_DELETE, 8'd4,   32'h0);
        send_op(KIND_DELETE, 8'd2,   32'h0);
        send_op(KIND_DELETE, 8'd255, 32'h0);
        send_op(KIND_DELETE, 8'd1,   32'h0);
        send_op(KIND_DELETE, 8'd1,   32'h0);
        send_op(KIND_DELETE, 8'd1,   32'h0);
    endtask

    // Segments lean toward growth, shrinkage or balance so that the list
    // regularly runs full and runs empty.
    task automatic run_random();
        int  insert_pct;
        int  mode;
        logic kind;
        logic [POS_W-1:0] position;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % PHASE_OPS == 0 && n != 0)
            begin
                drain_results();
                mode = (n / PHASE_OPS) % 4;
                send_idle_pct = (mode == 1) ? 72 : (mode == 3) ? 32 : 0;
                stall_pct     = (mode == 2) ? 72 : (mode == 3) ? 32 : 0;
                if (mode == 0)
                    hold_left = 300;
            end
            case ((n / SEGMENT_OPS) % 3)
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
            if ($urandom_range(99) < 12)
                position = POS_W'($urandom_range(255));
            else if (kind == KIND_INSERT)
                position = POS_W'($urandom_range(1, sb.length + 1));
            else
                position = (sb.length == 0) ? 8'd1 : POS_W'($urandom_range(1, sb.length));
            send_op(kind, position, $urandom);
            idle_gap();
        end
    endtask

    // Output monitor and receiver stalls.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("positional_list_insert_delete regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain_results();
        run_random();
        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("positional_list_insert_delete regression: pass");
        else
            $display("positional_list_insert_delete regression: fail");
        $finish;
    end

endmodule

/* sim.f */
design/plist_pkg.sv
design/plist_cell.sv
design/plist_ctrl.sv
design/positional_list_insert_delete.sv
design/plist_chk.sv
dv/tb_top.sv
